// ===== hdl/subset_sum_backtrack_search_core_macros.svh =====
// Assertion macros shared by the subset-sum search core.
`ifndef SUBSET_SUM_BACKTRACK_SEARCH_CORE_MACROS_SVH
`define SUBSET_SUM_BACKTRACK_SEARCH_CORE_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define SSBS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define SSBS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define SSBS_ASSERT(lbl, expr)
`define SSBS_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== hdl/ssbs_pkg.sv =====
// Shared types and constants of the subset-sum search core.
`default_nettype none

package ssbs_pkg;

    localparam int SUM_BITS        = 20;
    localparam int COUNT_BITS      = 5;
    localparam int IDX_BITS        = 4;
    localparam int IN_WEIGHT_BITS  = 16;
    localparam int MASK_BITS       = 16;
    localparam int MAX_ITEMS_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [SUM_BITS-1:0]   TARGET_RESET = SUM_BITS'(52);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET  = COUNT_BITS'(6);

    // configuration register indexes
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_FIND    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FIND_RD,
        ST_FIND_EV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [MASK_BITS-1:0] mask;
        logic                 done;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/ssbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/ssbs_search.sv =====
// Backtracking sequencer and search state of the subset-sum core.
`default_nettype none
`include "subset_sum_backtrack_search_core_macros.svh"

module ssbs_search import ssbs_pkg::*; #(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    localparam int AW         = $clog2(MAX_ITEMS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [1:0]                mode,
    input  wire logic [IDX_BITS-1:0]       item_index,
    input  wire logic [IN_WEIGHT_BITS-1:0] item_weight,
    input  wire logic [SUM_BITS-1:0]       target_sum,
    input  wire logic [COUNT_BITS-1:0]     item_count,
    output logic                           mem_we,
    output logic [AW-1:0]                  mem_waddr,
    output logic [WEIGHT_BITS-1:0]         mem_wdata,
    output logic [AW-1:0]                  mem_raddr,
    input  wire logic [WEIGHT_BITS-1:0]    mem_rdata,
    output rsp_t                           push,
    input  wire logic                      slot_free
);

    localparam int LW   = $clog2(MAX_ITEMS + 1);
    localparam int CMPW = ((WEIGHT_BITS > SUM_BITS) ? WEIGHT_BITS : SUM_BITS) + 1;
    localparam logic [COUNT_BITS:0]    MAX_CNT = (COUNT_BITS + 1)'(MAX_ITEMS);
    localparam logic [MAX_ITEMS-1:0]   ONE_BIT = MAX_ITEMS'(1);

    state_t                 state_reg, state_next;
    logic [SUM_BITS-1:0]    cur_reg, cur_next;
    logic [SUM_BITS-1:0]    rem_reg, rem_next;
    logic [MAX_ITEMS-1:0]   include_reg, include_next;
    logic [MAX_ITEMS-1:0]   tried_reg, tried_next;
    logic [LW-1:0]          level_reg, level_next;
    logic [LW-1:0]          active_reg, active_next;
    logic [LW-1:0]          sum_idx_reg, sum_idx_next;
    logic                   sum_vld_reg, sum_vld_next;
    logic                   running_reg, running_next;
    logic                   vp_reg, vp_next;
    logic                   found_reg, found_next;

    logic                   accept;
    mode_t                  req_mode;
    logic [LW-1:0]          clamped_count;
    logic [LW-1:0]          lvl_dec;
    logic [AW-1:0]          k_visit;
    logic [AW-1:0]          k_back;
    logic [SUM_BITS-1:0]    w_sum;
    logic [SUM_BITS:0]      reach_sum;
    logic [CMPW-1:0]        fit_sum;
    logic                   hit;
    logic                   promising;
    logic                   emit_now;

    assign accept   = req_valid && !req_stall;
    assign req_mode = mode_t'(mode);

    // clamp the item count to the store depth
    assign clamped_count = ({1'b0, item_count} > MAX_CNT) ? LW'(MAX_ITEMS)
                                                          : LW'(item_count);

    assign lvl_dec   = level_reg - LW'(1);
    assign k_visit   = level_reg[AW-1:0];
    assign k_back    = lvl_dec[AW-1:0];
    assign w_sum     = SUM_BITS'(mem_rdata);
    assign reach_sum = {1'b0, cur_reg} + {1'b0, rem_reg};
    assign fit_sum   = CMPW'(cur_reg) + CMPW'(mem_rdata);
    assign hit       = (cur_reg == target_sum);
    assign promising = (reach_sum >= {1'b0, target_sum})
                       && (hit || ((level_reg < active_reg)
                                   && (fit_sum <= CMPW'(target_sum))));
    assign emit_now  = vp_reg ? (promising && hit) : (level_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_mode)
                        MODE_FIND:    state_next = running_reg ? ST_FIND_RD : ST_EMIT;
                        MODE_RESTART: state_next = ST_SUM;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SUM:
            begin
                if (!sum_vld_reg && (sum_idx_reg >= active_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND_RD: state_next = ST_FIND_EV;
            ST_FIND_EV: state_next = emit_now ? ST_EMIT : ST_FIND_RD;
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_stall  = (state_reg != ST_IDLE);
        mem_we     = (state_reg == ST_IDLE) && accept && (req_mode == MODE_LOAD)
                     && (int'(item_index) < MAX_ITEMS);
        mem_waddr  = AW'(item_index);
        mem_wdata  = WEIGHT_BITS'(item_weight);
        case (state_reg)
            ST_SUM:     mem_raddr = sum_idx_reg[AW-1:0];
            ST_FIND_RD: mem_raddr = vp_reg ? k_visit : k_back;
            default:    mem_raddr = '0;
        endcase
        push.valid = (state_reg == ST_EMIT);
        push.found = found_reg;
        push.mask  = found_reg ? MASK_BITS'(include_reg) : '0;
        push.done  = !found_reg;
    end

    // search state update
    always_comb
    begin
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        include_next = include_reg;
        tried_next   = tried_reg;
        level_next   = level_reg;
        active_next  = active_reg;
        sum_idx_next = sum_idx_reg;
        sum_vld_next = sum_vld_reg;
        running_next = running_reg;
        vp_next      = vp_reg;
        found_next   = found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_mode == MODE_RESTART))
                begin
                    active_next  = clamped_count;
                    cur_next     = '0;
                    rem_next     = '0;
                    include_next = '0;
                    tried_next   = '0;
                    level_next   = '0;
                    sum_idx_next = '0;
                    sum_vld_next = 1'b0;
                    running_next = 1'b1;
                    vp_next      = 1'b1;
                end
                else if (accept && (req_mode == MODE_FIND) && !running_reg)
                begin
                    found_next = 1'b0;
                end
            end
            ST_SUM:
            begin
                // one read in flight; add the weight that came back
                if (sum_vld_reg)
                begin
                    rem_next = rem_reg + w_sum;
                end
                if (sum_idx_reg < active_reg)
                begin
                    sum_idx_next = sum_idx_reg + LW'(1);
                    sum_vld_next = 1'b1;
                end
                else
                begin
                    sum_vld_next = 1'b0;
                end
            end
            ST_FIND_EV:
            begin
                if (vp_reg)
                begin
                    vp_next = 1'b0;
                    if (promising && hit)
                    begin
                        found_next = 1'b1;
                    end
                    else if (promising)
                    begin
                        // descend with the item included
                        include_next = include_reg | (ONE_BIT << k_visit);
                        tried_next   = tried_reg & ~(ONE_BIT << k_visit);
                        cur_next     = cur_reg + w_sum;
                        rem_next     = rem_reg - w_sum;
                        level_next   = level_reg + LW'(1);
                        vp_next      = 1'b1;
                    end
                end
                else if (level_reg == '0)
                begin
                    running_next = 1'b0;
                    found_next   = 1'b0;
                end
                else if (!tried_reg[k_back])
                begin
                    // switch to the exclude branch
                    tried_next   = tried_reg | (ONE_BIT << k_back);
                    include_next = include_reg & ~(ONE_BIT << k_back);
                    cur_next     = cur_reg - w_sum;
                    vp_next      = 1'b1;
                end
                else
                begin
                    // both branches done: pop one level
                    tried_next   = tried_reg & ~(ONE_BIT << k_back);
                    include_next = include_reg & ~(ONE_BIT << k_back);
                    rem_next     = rem_reg + w_sum;
                    level_next   = lvl_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            rem_reg     <= '0;
            include_reg <= '0;
            tried_reg   <= '0;
            level_reg   <= '0;
            active_reg  <= '0;
            sum_idx_reg <= '0;
            sum_vld_reg <= 1'b0;
            running_reg <= 1'b0;
            vp_reg      <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
            include_reg <= include_next;
            tried_reg   <= tried_next;
            level_reg   <= level_next;
            active_reg  <= active_next;
            sum_idx_reg <= sum_idx_next;
            sum_vld_reg <= sum_vld_next;
            running_reg <= running_next;
            vp_reg      <= vp_next;
            found_reg   <= found_next;
        end
    end

    `SSBS_ASSERT(a_level_bound, level_reg <= active_reg)
    `SSBS_ASSERT(a_masks_below_level, ((include_reg | tried_reg) >> level_reg) == '0)
    `SSBS_ASSERT(a_found_hits, !((state_reg == ST_EMIT) && found_reg) || hit)
    `SSBS_ASSERT_NEXT(a_restart_clears, accept && (req_mode == MODE_RESTART), (state_reg == ST_SUM) && (level_reg == '0) && (include_reg == '0))

endmodule

`default_nettype wire

// ===== hdl/ssbs_out.sv =====
// Result holding register between the search sequencer and the result channel.
`default_nettype none
`include "subset_sum_backtrack_search_core_macros.svh"

module ssbs_out import ssbs_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rsp_t                 push,
    output logic                      slot_free,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic                      found,
    output logic [MASK_BITS-1:0]      subset_mask,
    output logic                      search_done
);

    logic                 valid_reg, valid_next;
    logic                 found_reg;
    logic [MASK_BITS-1:0] mask_reg;
    logic                 done_reg;
    logic                 load;

    assign slot_free = !valid_reg || !rsp_stall;
    assign load      = push.valid && slot_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload until the response is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= push.found;
            mask_reg  <= push.mask;
            done_reg  <= push.done;
        end
    end

    assign rsp_valid   = valid_reg;
    assign found       = found_reg;
    assign subset_mask = mask_reg;
    assign search_done = done_reg;

    `SSBS_ASSERT_NEXT(a_load_shows, load, valid_reg)
    `SSBS_ASSERT(a_found_or_done, !valid_reg || (found_reg != done_reg))
    `SSBS_ASSERT(a_mask_only_found, !valid_reg || found_reg || (mask_reg == '0))

endmodule

`default_nettype wire

// ===== hdl/subset_sum_backtrack_search_core.sv =====
// Top level of the subset-sum backtracking search core.
// Depth-first subset-sum search over up to MAX_ITEMS weights held in a small
// synchronous RAM. A load request writes one weight. A restart request sweeps
// the first item_count weights through the RAM read port to form the
// remaining-weight total. A find request resumes the walk; each search step is
// one RAM read followed by one evaluate-and-update, so the length of a find
// depends on the weights and the target. One request is worked at a time; a
// finished result waits in an output register while the next request is taken.
// Weights should be loaded in nondecreasing order, and every position a search
// reaches must have been loaded. Configuration writes belong in idle periods;
// item_count is latched at restart and clamped to MAX_ITEMS.
`default_nettype none

module subset_sum_backtrack_search_core import ssbs_pkg::*; #(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [SUM_BITS-1:0]       cfg_data,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [1:0]                mode,
    input  wire logic [IDX_BITS-1:0]       item_index,
    input  wire logic [IN_WEIGHT_BITS-1:0] item_weight,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output logic                           found,
    output logic [MASK_BITS-1:0]           subset_mask,
    output logic                           search_done
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic [SUM_BITS-1:0]   target_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic [WEIGHT_BITS-1:0] mem_rdata;
    rsp_t                   push;
    logic                   slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET: target_reg <= cfg_data;
                CFG_COUNT:  count_reg  <= cfg_data[COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ssbs_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_weights (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ssbs_search #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .item_index  (item_index),
        .item_weight (item_weight),
        .target_sum  (target_reg),
        .item_count  (count_reg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .push        (push),
        .slot_free   (slot_free)
    );

    ssbs_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .slot_free   (slot_free),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .found       (found),
        .subset_mask (subset_mask),
        .search_done (search_done)
    );

endmodule

`default_nettype wire
